// ----- hw/rtl/bpcw_pkg.sv -----
package bpcw_pkg;

  // Packet limit and derived counts
  localparam int MAX_PACKET = 266;
  localparam int CNT_W      = $clog2(MAX_PACKET);
  localparam logic [CNT_W-1:0] LIMIT_1M = CNT_W'(MAX_PACKET - 8);
  localparam logic [CNT_W-1:0] LIMIT_2M = CNT_W'(MAX_PACKET - 9);

  localparam int MAX_RES   = 7;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ACCESS_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RF_CHANNEL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHY_RATE    = 2'd3;

  localparam logic [31:0] RST_ACCESS_ADDR = 32'h8E89_BED6;
  localparam logic [23:0] RST_CRC_SEED    = 24'h55_5555;
  localparam logic [5:0]  RST_RF_CHANNEL  = 6'd37;
  localparam logic [1:0]  RST_PHY_RATE    = 2'd1;
  localparam logic [1:0]  RATE_2M         = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_LONG  = 2'd2;

  localparam logic [23:0] CRC_POLY  = 24'h00_065B;
  localparam logic [7:0]  LFSR_TAP  = 8'h88;
  localparam logic [7:0]  PRE_ONE   = 8'h55;
  localparam logic [7:0]  PRE_ZERO  = 8'hAA;

  typedef struct packed {
    logic [31:0] access_address;
    logic [23:0] crc_seed;
    logic [5:0]  rf_channel;
    logic [1:0]  phy_rate;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]   items;
    logic [RES_CNT_W-1:0] count;
  } batch_t;

  typedef struct packed {
    logic [6:0] lfsr;
    logic [7:0] data;
  } whiten_t;

  // CRC-24, data LSB first, eight steps unrolled
  function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] d);
    logic [23:0] c;
    logic        fb;
    c = crc;
    for (int b = 0; b < 8; b++) begin
      fb = c[23] ^ d[b];
      c  = {c[22:0], 1'b0} ^ (fb ? CRC_POLY : 24'h0);
    end
    return c;
  endfunction

  // 7-bit whitening LFSR, one step per bit
  function automatic whiten_t whiten_byte(input logic [6:0] lfsr, input logic [7:0] v);
    whiten_t    r;
    logic [7:0] t;
    r.lfsr = lfsr;
    r.data = v;
    for (int b = 0; b < 8; b++) begin
      t = {1'b0, r.lfsr};
      if (r.lfsr[0]) begin
        r.data[b] = ~r.data[b];
        t = t ^ LFSR_TAP;
      end
      r.lfsr = t[7:1];
    end
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/bpcw_ifs.sv -----
interface bpcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pdu_byte;
  logic       last_byte;

  modport source(output valid, pdu_byte, last_byte, input ready);
  modport sink(input valid, pdu_byte, last_byte, output ready);
endinterface

interface bpcw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;
  logic [1:0] status;

  modport source(output valid, out_byte, end_of_packet, status, input ready);
  modport sink(input valid, out_byte, end_of_packet, status, output ready);
endinterface

// ----- hw/rtl/bpcw_assemble.sv -----
module bpcw_assemble (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       pdu_byte,
  input  logic             last_byte,
  input  bpcw_pkg::cfg_t   cfg,
  output bpcw_pkg::batch_t batch
);
  import bpcw_pkg::*;

  logic [23:0]      crc_reg, crc_reg_next;
  logic [6:0]       whiten_lfsr, whiten_lfsr_next;
  logic [CNT_W-1:0] pdu_count, pdu_count_next;
  logic             too_long, too_long_next;

  logic                 start, two_m, over, tl, is_short, err;
  logic [23:0]          crc_start, crc_data;
  logic [6:0]           lfsr_start;
  logic [CNT_W-1:0]     limit, n, n_cap;
  whiten_t              w_data, w_c0, w_c1, w_c2;
  logic [7:0]           pat;
  logic [7:0]           hdr [MAX_RES];
  res_t                 payload [4];
  logic [RES_CNT_W-1:0] pre, rel;

  always_comb begin
    start      = (pdu_count == '0);
    crc_start  = start ? cfg.crc_seed : crc_reg;
    lfsr_start = start ? {1'b1, cfg.rf_channel} : whiten_lfsr;
    two_m      = (cfg.phy_rate == RATE_2M);
    limit      = two_m ? LIMIT_2M : LIMIT_1M;
    n          = pdu_count + 1'b1;
    over       = (n > limit);
    n_cap      = over ? limit + 1'b1 : n;
    tl         = (start ? 1'b0 : too_long) | over;
    is_short   = (n_cap < CNT_W'(2));
    err        = last_byte && (is_short || tl);

    crc_data = crc_feed(crc_start, pdu_byte);
    w_data   = whiten_byte(lfsr_start, pdu_byte);
    w_c0     = whiten_byte(w_data.lfsr, rev8(crc_data[23:16]));
    w_c1     = whiten_byte(w_c0.lfsr, rev8(crc_data[15:8]));
    w_c2     = whiten_byte(w_c1.lfsr, rev8(crc_data[7:0]));

    // preamble then address LSB first
    pat    = cfg.access_address[0] ? PRE_ONE : PRE_ZERO;
    hdr[0] = pat;
    hdr[6] = 8'h00;
    if (two_m) begin
      hdr[1] = pat;
      hdr[2] = cfg.access_address[7:0];
      hdr[3] = cfg.access_address[15:8];
      hdr[4] = cfg.access_address[23:16];
      hdr[5] = cfg.access_address[31:24];
    end else begin
      hdr[1] = cfg.access_address[7:0];
      hdr[2] = cfg.access_address[15:8];
      hdr[3] = cfg.access_address[23:16];
      hdr[4] = cfg.access_address[31:24];
      hdr[5] = 8'h00;
    end
    pre = start ? (two_m ? RES_CNT_W'(6) : RES_CNT_W'(5)) : '0;

    payload[0] = '{out_byte: w_data.data, end_of_packet: 1'b0, status: STATUS_OK};
    payload[1] = '{out_byte: w_c0.data,   end_of_packet: 1'b0, status: STATUS_OK};
    payload[2] = '{out_byte: w_c1.data,   end_of_packet: 1'b0, status: STATUS_OK};
    payload[3] = '{out_byte: w_c2.data,   end_of_packet: 1'b1, status: STATUS_OK};

    for (int k = 0; k < MAX_RES; k++) begin
      rel = RES_CNT_W'(k) - pre;
      if (RES_CNT_W'(k) < pre) begin
        batch.items[k] = '{out_byte: hdr[k], end_of_packet: 1'b0, status: STATUS_OK};
      end else begin
        batch.items[k] = payload[rel[1:0]];
      end
    end

    crc_reg_next     = crc_reg;
    whiten_lfsr_next = whiten_lfsr;
    pdu_count_next   = pdu_count;
    too_long_next    = too_long;

    if (err) begin
      batch.items[0] = '{out_byte: 8'h00, end_of_packet: 1'b1,
                         status: is_short ? STATUS_SHORT : STATUS_LONG};
      batch.count    = RES_CNT_W'(1);
      pdu_count_next = '0;
      too_long_next  = 1'b0;
    end else if (tl) begin
      // overlong: swallow the word, cap the count at limit + 1
      batch.count      = '0;
      pdu_count_next   = n_cap;
      too_long_next    = 1'b1;
      crc_reg_next     = crc_start;
      whiten_lfsr_next = lfsr_start;
    end else begin
      batch.count      = pre + RES_CNT_W'(1) + (last_byte ? RES_CNT_W'(3) : RES_CNT_W'(0));
      crc_reg_next     = crc_data;
      whiten_lfsr_next = last_byte ? w_c2.lfsr : w_data.lfsr;
      pdu_count_next   = last_byte ? '0 : n_cap;
      too_long_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg     <= '0;
      whiten_lfsr <= '0;
      pdu_count   <= '0;
      too_long    <= 1'b0;
    end else if (step) begin
      crc_reg     <= crc_reg_next;
      whiten_lfsr <= whiten_lfsr_next;
      pdu_count   <= pdu_count_next;
      too_long    <= too_long_next;
    end
  end

endmodule

// ----- hw/rtl/bpcw_outbuf.sv -----
module bpcw_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_req,
  input  bpcw_pkg::batch_t batch,
  output logic             free,
  bpcw_out_if.source       pkt_out
);
  import bpcw_pkg::*;

  res_t [MAX_RES-1:0]   items, items_next;
  logic [RES_CNT_W-1:0] cnt;
  logic                 take, load;

  assign take = pkt_out.valid && pkt_out.ready;
  // free once the last buffered word leaves
  assign free = (cnt == '0) || ((cnt == RES_CNT_W'(1)) && take);
  assign load = load_req && free;

  assign pkt_out.valid         = (cnt != '0);
  assign pkt_out.out_byte      = items[0].out_byte;
  assign pkt_out.end_of_packet = items[0].end_of_packet;
  assign pkt_out.status        = items[0].status;

  always_comb begin
    if (load) begin
      items_next = batch.items;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        items_next[i] = items[i+1];
      end
      items_next[MAX_RES-1] = items[MAX_RES-1];
    end else begin
      items_next = items;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= batch.count;
    end else if (take) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    items <= items_next;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= RES_CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pkt_out.valid && !pkt_out.ready |=> pkt_out.valid && $stable(cnt))
    else $error("buffer changed during stall");

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    pkt_out.valid && pkt_out.status != STATUS_OK |->
      pkt_out.end_of_packet && pkt_out.out_byte == 8'h00 && cnt == RES_CNT_W'(1))
    else $error("error word not a lone end word");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load && batch.count != '0 |=> pkt_out.valid)
    else $error("loaded words not presented");

endmodule

// ----- hw/rtl/ble_packet_crc_whiten_builder.sv -----
// An accepted input word is registered in s1; its results are then loaded into
// the result buffer. Throughput: one input word per cycle while each yields at
// most one result and pkt_out is ready; a word with more results holds the input
// while the single output port drains the buffer one word per ready cycle (up
// to 7 for a packet start). Reset (rst, synchronous): config registers take
// their reset values, the packet state starts empty and both stages are flushed.
module ble_packet_crc_whiten_builder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bpcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpcw_pkg::CFG_DATA_W-1:0] cfg_data,
  bpcw_in_if.sink                        pdu_in,
  bpcw_out_if.source                     pkt_out
);
  import bpcw_pkg::*;

  cfg_t   cfg;
  batch_t batch;

  // Input register: one PDU word waiting for the assembler
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go;
  logic       buf_free;

  // Config writes; the user keeps them to idle times, as the block does not enforce it and has no mid-packet handling
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.access_address <= RST_ACCESS_ADDR;
      cfg.crc_seed       <= RST_CRC_SEED;
      cfg.rf_channel     <= RST_RF_CHANNEL;
      cfg.phy_rate       <= RST_PHY_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCESS_ADDR: cfg.access_address <= cfg_data;
        REG_CRC_SEED:    cfg.crc_seed       <= cfg_data[23:0];
        REG_RF_CHANNEL:  cfg.rf_channel     <= cfg_data[5:0];
        REG_PHY_RATE:    cfg.phy_rate       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // The word in s1 moves on when the result buffer can take its batch;
  // a new word enters in the same cycle.
  assign s1_go        = s1_valid && buf_free;
  assign pdu_in.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pdu_in.ready) begin
      s1_valid <= pdu_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pdu_in.valid && pdu_in.ready) begin
      s1_byte <= pdu_in.pdu_byte;
      s1_last <= pdu_in.last_byte;
    end
  end

  // CRC, whitening, preamble/address and error decision, all in one pass
  bpcw_assemble u_assemble (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .pdu_byte  (s1_byte),
    .last_byte (s1_last),
    .cfg       (cfg),
    .batch     (batch)
  );

  // Result buffer: shifts out up to 7 words, one per cycle while pkt_out is ready
  bpcw_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load_req (s1_valid),
    .batch    (batch),
    .free     (buf_free),
    .pkt_out  (pkt_out)
  );

endmodule
